// File: design/assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: design/thrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package thrp_pkg;

  localparam int PAY_USED = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = 1;

  localparam logic [7:0] HDR_BYTE = 8'hCA;
  localparam logic [7:0] MIN_LEN = 8'd4;
  localparam logic [7:0] PING_LEN = 8'd5;

  localparam logic [7:0] OP_COOLED = 8'hA0;
  localparam logic [7:0] OP_FOV = 8'hA1;
  localparam logic [7:0] OP_NUC = 8'hA2;
  localparam logic [7:0] OP_NUC_TABLE = 8'hA4;
  localparam logic [7:0] OP_POLARITY = 8'hA5;
  localparam logic [7:0] OP_RETICLE = 8'hA7;
  localparam logic [7:0] OP_DZOOM = 8'hA9;
  localparam logic [7:0] OP_FREEZE = 8'hAA;
  localparam logic [7:0] OP_AGC = 8'hAE;
  localparam logic [7:0] OP_BRIGHT = 8'hAF;
  localparam logic [7:0] OP_CONTRAST = 8'hB1;
  localparam logic [7:0] OP_RET_INT = 8'hB5;
  localparam logic [7:0] OP_IBIT = 8'hBB;
  localparam logic [7:0] OP_LENS = 8'hBC;
  localparam logic [7:0] OP_VERSION = 8'hC2;
  localparam logic [7:0] OP_EXT = 8'hC3;

  localparam logic [7:0] SUB_IPM = 8'hD7;
  localparam logic [7:0] SUB_HPF_GAIN = 8'hD8;
  localparam logic [7:0] SUB_HPF_SPAT = 8'hD9;
  localparam logic [7:0] SUB_UPD_SPEED = 8'hDE;
  localparam logic [7:0] SUB_VERSION = 8'hB4;
  localparam logic [7:0] DZOOM_ON = 8'h02;

  localparam logic [4:0] REG_COOLED = 5'd0;
  localparam logic [4:0] REG_FOV = 5'd1;
  localparam logic [4:0] REG_ZOOM = 5'd2;
  localparam logic [4:0] REG_FOCUS = 5'd3;
  localparam logic [4:0] REG_ANGLE = 5'd4;
  localparam logic [4:0] REG_NUC_TABLE = 5'd5;
  localparam logic [4:0] REG_POLARITY = 5'd6;
  localparam logic [4:0] REG_RETICLE = 5'd7;
  localparam logic [4:0] REG_DZOOM = 5'd8;
  localparam logic [4:0] REG_FREEZE = 5'd9;
  localparam logic [4:0] REG_AGC = 5'd10;
  localparam logic [4:0] REG_BRIGHT = 5'd11;
  localparam logic [4:0] REG_CONTRAST = 5'd12;
  localparam logic [4:0] REG_RET_INT = 5'd13;
  localparam logic [4:0] REG_NUC = 5'd14;
  localparam logic [4:0] REG_IBIT = 5'd15;
  localparam logic [4:0] REG_IPM = 5'd16;
  localparam logic [4:0] REG_HPF_GAIN = 5'd17;
  localparam logic [4:0] REG_HPF_SPAT = 5'd18;
  localparam logic [4:0] REG_UPD_SPEED = 5'd19;
  localparam logic [4:0] REG_FPGA_VER = 5'd20;
  localparam logic [4:0] REG_SYS_VER = 5'd21;
  localparam logic [4:0] REG_VER = 5'd22;

  typedef enum logic [1:0] {
    KIND_UPDATE    = 2'd0,
    KIND_PING      = 2'd1,
    KIND_CSUM_ERR  = 2'd2,
    KIND_NO_UPDATE = 2'd3
  } kind_t;

  // finished frame handed from the parser to the expander
  typedef struct packed {
    kind_t                       status;
    logic [7:0]                  opcode;
    logic [PAY_USED-1:0][7:0]    pay;
  } desc_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  reg_id;
    logic [15:0] reg_value;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: design/thrp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module thrp_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = thrp_pkg::QUEUE_AW;
  localparam int DEPTH = thrp_pkg::QUEUE_DEPTH;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: design/thrp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module thrp_front #(
  parameter int SAVED_PAYLOAD_BYTES = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_take,
  input  wire logic [7:0] rx_byte,
  output logic            desc_push,
  output thrp_pkg::desc_t desc
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] op_r, op_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] pay_r [SAVED_PAYLOAD_BYTES];
  logic [7:0] pay_nxt [SAVED_PAYLOAD_BYTES];
  logic       frame_end;

  assign frame_end = ({1'b0, cnt_r} + 9'd1) >= {1'b0, len_r};

  always_comb begin
    desc.opcode = op_r;
    for (int i = 0; i < thrp_pkg::PAY_USED; i++) begin
      desc.pay[i] = pay_r[i];
    end
    if (len_r == thrp_pkg::PING_LEN && op_r == thrp_pkg::OP_EXT) begin
      desc.status = thrp_pkg::KIND_PING;
    end else if ((8'h00 - sum_r) != rx_byte) begin
      desc.status = thrp_pkg::KIND_CSUM_ERR;
    end else begin
      desc.status = thrp_pkg::KIND_UPDATE;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    sum_nxt   = sum_r;
    pay_nxt   = pay_r;
    desc_push = 1'b0;
    if (byte_take) begin
      case (phase_r)
        PH_LEN: begin
          if (rx_byte < thrp_pkg::MIN_LEN) begin
            phase_nxt = PH_HUNT;
          end else begin
            len_nxt   = rx_byte;
            sum_nxt   = sum_r + rx_byte;
            cnt_nxt   = 8'd2;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (frame_end) begin
            phase_nxt = PH_HUNT;
            desc_push = 1'b1;
          end else begin
            if (cnt_r == 8'd2) begin
              op_nxt = rx_byte;
            end
            for (int i = 0; i < SAVED_PAYLOAD_BYTES; i++) begin
              if (cnt_r == 8'(i + 3)) begin
                pay_nxt[i] = rx_byte;
              end
            end
            sum_nxt = sum_r + rx_byte;
            cnt_nxt = cnt_r + 8'd1;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (rx_byte == thrp_pkg::HDR_BYTE) begin
            for (int i = 0; i < SAVED_PAYLOAD_BYTES; i++) begin
              pay_nxt[i] = 8'h00;
            end
            op_nxt    = 8'h00;
            sum_nxt   = rx_byte;
            cnt_nxt   = 8'd1;
            phase_nxt = PH_LEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    pay_r <= pay_nxt;
  end

endmodule

`default_nettype wire

// File: design/thrp_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module thrp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              desc_valid,
  input  wire thrp_pkg::desc_t   desc,
  output logic                   desc_pop,
  output logic                   res_push,
  output thrp_pkg::result_t      res,
  input  wire logic              res_full
);

  function automatic logic [1:0] res_count(input thrp_pkg::desc_t d);
    logic [1:0] n;
    n = 2'd1;
    if (d.status == thrp_pkg::KIND_UPDATE) begin
      if (d.opcode == thrp_pkg::OP_LENS) begin
        n = 2'd3;
      end else if (d.opcode == thrp_pkg::OP_VERSION && d.pay[0] == thrp_pkg::SUB_VERSION) begin
        n = 2'd3;
      end
    end
    return n;
  endfunction

  function automatic thrp_pkg::result_t res_item(input thrp_pkg::desc_t d,
                                                 input logic [1:0] k);
    thrp_pkg::result_t r;
    r.kind      = thrp_pkg::KIND_NO_UPDATE;
    r.reg_id    = '0;
    r.reg_value = '0;
    r.last      = 1'b0;
    case (d.status)
      thrp_pkg::KIND_PING:     r.kind = thrp_pkg::KIND_PING;
      thrp_pkg::KIND_CSUM_ERR: r.kind = thrp_pkg::KIND_CSUM_ERR;
      thrp_pkg::KIND_UPDATE: begin
        r.kind      = thrp_pkg::KIND_UPDATE;
        r.reg_value = {8'h00, d.pay[0]};
        case (d.opcode)
          thrp_pkg::OP_COOLED:    r.reg_id = thrp_pkg::REG_COOLED;
          thrp_pkg::OP_FOV:       r.reg_id = thrp_pkg::REG_FOV;
          thrp_pkg::OP_NUC_TABLE: r.reg_id = thrp_pkg::REG_NUC_TABLE;
          thrp_pkg::OP_POLARITY:  r.reg_id = thrp_pkg::REG_POLARITY;
          thrp_pkg::OP_RETICLE:   r.reg_id = thrp_pkg::REG_RETICLE;
          thrp_pkg::OP_FREEZE:    r.reg_id = thrp_pkg::REG_FREEZE;
          thrp_pkg::OP_BRIGHT:    r.reg_id = thrp_pkg::REG_BRIGHT;
          thrp_pkg::OP_CONTRAST:  r.reg_id = thrp_pkg::REG_CONTRAST;
          thrp_pkg::OP_RET_INT:   r.reg_id = thrp_pkg::REG_RET_INT;
          thrp_pkg::OP_NUC:       r.reg_id = thrp_pkg::REG_NUC;
          thrp_pkg::OP_IBIT:      r.reg_id = thrp_pkg::REG_IBIT;
          thrp_pkg::OP_DZOOM: begin
            r.reg_id    = thrp_pkg::REG_DZOOM;
            r.reg_value = {15'd0, d.pay[0] == thrp_pkg::DZOOM_ON};
          end
          thrp_pkg::OP_AGC: begin
            r.reg_id    = thrp_pkg::REG_AGC;
            r.reg_value = {15'd0, d.pay[0] == 8'h00};
          end
          thrp_pkg::OP_LENS: begin
            case (k)
              2'd0: begin
                r.reg_id    = thrp_pkg::REG_ZOOM;
                r.reg_value = {d.pay[1], 8'h00};
              end
              2'd1: begin
                r.reg_id    = thrp_pkg::REG_FOCUS;
                r.reg_value = {d.pay[3], d.pay[2]};
              end
              default: begin
                r.reg_id    = thrp_pkg::REG_ANGLE;
                r.reg_value = {d.pay[5], d.pay[4]};
              end
            endcase
          end
          thrp_pkg::OP_EXT: begin
            r.reg_value = {8'h00, d.pay[1]};
            case (d.pay[0])
              thrp_pkg::SUB_IPM:       r.reg_id = thrp_pkg::REG_IPM;
              thrp_pkg::SUB_HPF_GAIN:  r.reg_id = thrp_pkg::REG_HPF_GAIN;
              thrp_pkg::SUB_HPF_SPAT:  r.reg_id = thrp_pkg::REG_HPF_SPAT;
              thrp_pkg::SUB_UPD_SPEED: r.reg_id = thrp_pkg::REG_UPD_SPEED;
              default: begin
                r.kind      = thrp_pkg::KIND_NO_UPDATE;
                r.reg_value = '0;
              end
            endcase
          end
          thrp_pkg::OP_VERSION: begin
            if (d.pay[0] == thrp_pkg::SUB_VERSION) begin
              case (k)
                2'd0: begin
                  r.reg_id    = thrp_pkg::REG_FPGA_VER;
                  r.reg_value = {8'h00, d.pay[3]};
                end
                2'd1: begin
                  r.reg_id    = thrp_pkg::REG_SYS_VER;
                  r.reg_value = {8'h00, d.pay[4]};
                end
                default: begin
                  r.reg_id    = thrp_pkg::REG_VER;
                  r.reg_value = {8'h00, d.pay[5]};
                end
              endcase
            end else begin
              r.kind      = thrp_pkg::KIND_NO_UPDATE;
              r.reg_value = '0;
            end
          end
          default: begin
            r.kind      = thrp_pkg::KIND_NO_UPDATE;
            r.reg_value = '0;
          end
        endcase
      end
      default: r.kind = thrp_pkg::KIND_NO_UPDATE;
    endcase
    return r;
  endfunction

  thrp_pkg::desc_t cur_r, cur_nxt;
  logic            cur_v_r, cur_v_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [1:0]      cnt;
  logic            emit, done, take;

  assign cnt      = res_count(cur_r);
  assign emit     = cur_v_r && !res_full;
  assign done     = emit && res.last;
  assign take     = desc_valid && (!cur_v_r || done);
  assign desc_pop = take;
  assign res_push = emit;

  always_comb begin
    res      = res_item(cur_r, idx_r);
    res.last = (idx_r == cnt - 2'd1);
  end

  always_comb begin
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (take) begin
      cur_nxt   = desc;
      cur_v_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (done) begin
      cur_v_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  `ASSERT_IMP(a_idx_range, clk, rst_n, cur_v_r, idx_r < cnt)
  `ASSERT_NXT(a_take_load, clk, rst_n, take, cur_v_r && idx_r == 2'd0)
  `ASSERT_NXT(a_idx_step, clk, rst_n, emit && !res.last, idx_r == $past(idx_r) + 2'd1)
  `ASSERT_IMP(a_single_status, clk, rst_n, emit && res.kind != thrp_pkg::KIND_UPDATE, res.last)

endmodule

`default_nettype wire

// File: design/thermal_head_reply_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// camera link reply parser: takes one received byte per cycle whenever in_full is low, hunts
// for the 0xca header, checks the two's-complement checksum and turns each complete frame
// into one to three result words, handed out one per cycle through a two-word output queue
// while that queue has room. a frame's first result passes the parser, the two-entry frame
// queue, the expander and the output queue before it can be popped. frames are at least four
// bytes long and give at most three results, so the expander keeps up with the byte stream;
// in_full rises only when the output side stalls long enough to fill the frame queue.

module thermal_head_reply_parser_core #(
  parameter int SAVED_PAYLOAD_BYTES = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic [7:0]  in_rx_byte,
  output logic             in_full,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_kind,
  output logic [4:0]       out_reg_id,
  output logic [15:0]      out_reg_value,
  output logic             out_last
);

  thrp_pkg::desc_t   fr_desc, bk_desc;
  thrp_pkg::result_t bk_res, q_res;
  logic              fr_push, dq_empty, bk_pop, bk_push, oq_full, byte_take;

  assign byte_take = in_push && !in_full;

  thrp_front #(
    .SAVED_PAYLOAD_BYTES(SAVED_PAYLOAD_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .rx_byte   (in_rx_byte),
    .desc_push (fr_push),
    .desc      (fr_desc)
  );

  thrp_fifo #(
    .WIDTH($bits(thrp_pkg::desc_t))
  ) u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .wdata (fr_desc),
    .full  (in_full),
    .pop   (bk_pop),
    .rdata (bk_desc),
    .empty (dq_empty)
  );

  thrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (!dq_empty),
    .desc       (bk_desc),
    .desc_pop   (bk_pop),
    .res_push   (bk_push),
    .res        (bk_res),
    .res_full   (oq_full)
  );

  thrp_fifo #(
    .WIDTH($bits(thrp_pkg::result_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_push),
    .wdata (bk_res),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (q_res),
    .empty (out_empty)
  );

  assign out_kind      = q_res.kind;
  assign out_reg_id    = q_res.reg_id;
  assign out_reg_value = q_res.reg_value;
  assign out_last      = q_res.last;

endmodule

`default_nettype wire

// File: tb/sv/thermal_head_reply_parser_core_tb.sv
`timescale 1ns / 1ps

module thermal_head_reply_parser_core_tb;
  import thrp_pkg::*;

  typedef enum logic [1:0] {
    LINK_HUNT   = 2'd0,
    LINK_LENGTH = 2'd1,
    LINK_BODY   = 2'd2
  } link_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_kind;
  logic [4:0]  out_reg_id;
  logic [15:0] out_reg_value;
  logic        out_last;

  thermal_head_reply_parser_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_rx_byte   (in_rx_byte),
    .in_full      (in_full),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_kind     (out_kind),
    .out_reg_id   (out_reg_id),
    .out_reg_value(out_reg_value),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // parser mirror
  link_phase_t lk_phase = LINK_HUNT;
  logic [7:0]  lk_len = 8'h00;
  logic [7:0]  lk_count = 8'h00;
  logic [7:0]  lk_op = 8'h00;
  logic [7:0]  lk_sum = 8'h00;
  logic [7:0]  lk_pay [6];

  result_t     frame_out [3];
  int          frame_n;
  result_t     reply_q [$];
  result_t     want_res;
  logic [7:0]  link_bytes [$];
  logic [7:0]  frame_pay [$];
  int          fail_count = 0;

  logic [7:0]  plain_ops [11] = '{OP_COOLED, OP_FOV, OP_NUC_TABLE, OP_POLARITY, OP_RETICLE,
                                   OP_FREEZE, OP_BRIGHT, OP_CONTRAST, OP_RET_INT, OP_NUC,
                                   OP_IBIT};
  logic [7:0]  ext_subs [4] = '{SUB_IPM, SUB_HPF_GAIN, SUB_HPF_SPAT, SUB_UPD_SPEED};

  task automatic add_result(input kind_t k, input logic [4:0] id, input logic [15:0] v);
    frame_out[frame_n].kind = k;
    frame_out[frame_n].reg_id = id;
    frame_out[frame_n].reg_value = v;
    frame_out[frame_n].last = 1'b0;
    frame_n++;
  endtask

  task automatic decode_frame();
    logic [4:0] id;
    bit         has_id;
    id = 5'd0;
    has_id = 1'b0;
    case (lk_op)
      OP_COOLED:    begin id = REG_COOLED;    has_id = 1'b1; end
      OP_FOV:       begin id = REG_FOV;       has_id = 1'b1; end
      OP_NUC_TABLE: begin id = REG_NUC_TABLE; has_id = 1'b1; end
      OP_POLARITY:  begin id = REG_POLARITY;  has_id = 1'b1; end
      OP_RETICLE:   begin id = REG_RETICLE;   has_id = 1'b1; end
      OP_FREEZE:    begin id = REG_FREEZE;    has_id = 1'b1; end
      OP_BRIGHT:    begin id = REG_BRIGHT;    has_id = 1'b1; end
      OP_CONTRAST:  begin id = REG_CONTRAST;  has_id = 1'b1; end
      OP_RET_INT:   begin id = REG_RET_INT;   has_id = 1'b1; end
      OP_NUC:       begin id = REG_NUC;       has_id = 1'b1; end
      OP_IBIT:      begin id = REG_IBIT;      has_id = 1'b1; end
      OP_DZOOM: begin
        add_result(KIND_UPDATE, REG_DZOOM, (lk_pay[0] == DZOOM_ON) ? 16'd1 : 16'd0);
      end
      OP_AGC: begin
        add_result(KIND_UPDATE, REG_AGC, (lk_pay[0] == 8'h00) ? 16'd1 : 16'd0);
      end
      OP_LENS: begin
        add_result(KIND_UPDATE, REG_ZOOM, {lk_pay[1], 8'h00});
        add_result(KIND_UPDATE, REG_FOCUS, {lk_pay[3], lk_pay[2]});
        add_result(KIND_UPDATE, REG_ANGLE, {lk_pay[5], lk_pay[4]});
      end
      OP_EXT: begin
        case (lk_pay[0])
          SUB_IPM:       add_result(KIND_UPDATE, REG_IPM, {8'h00, lk_pay[1]});
          SUB_HPF_GAIN:  add_result(KIND_UPDATE, REG_HPF_GAIN, {8'h00, lk_pay[1]});
          SUB_HPF_SPAT:  add_result(KIND_UPDATE, REG_HPF_SPAT, {8'h00, lk_pay[1]});
          SUB_UPD_SPEED: add_result(KIND_UPDATE, REG_UPD_SPEED, {8'h00, lk_pay[1]});
          default: ;
        endcase
      end
      OP_VERSION: begin
        if (lk_pay[0] == SUB_VERSION) begin
          add_result(KIND_UPDATE, REG_FPGA_VER, {8'h00, lk_pay[3]});
          add_result(KIND_UPDATE, REG_SYS_VER, {8'h00, lk_pay[4]});
          add_result(KIND_UPDATE, REG_VER, {8'h00, lk_pay[5]});
        end
      end
      default: ;
    endcase
    if (has_id) add_result(KIND_UPDATE, id, {8'h00, lk_pay[0]});
    if (frame_n == 0) add_result(KIND_NO_UPDATE, 5'd0, 16'd0);
  endtask

  task automatic track_link_byte(input logic [7:0] b);
    logic [7:0] csum;
    int         i;
    case (lk_phase)
      LINK_LENGTH: begin
        if (b < MIN_LEN) begin
          lk_phase = LINK_HUNT;
        end else begin
          lk_len = b;
          lk_sum = lk_sum + b;
          lk_count = 8'd2;
          lk_phase = LINK_BODY;
        end
      end
      LINK_BODY: begin
        if ({1'b0, lk_count} + 9'd1 >= {1'b0, lk_len}) begin
          lk_phase = LINK_HUNT;
          frame_n = 0;
          csum = 8'h00 - lk_sum;
          if (lk_len == PING_LEN && lk_op == OP_EXT) add_result(KIND_PING, 5'd0, 16'd0);
          else if (csum != b) add_result(KIND_CSUM_ERR, 5'd0, 16'd0);
          else decode_frame();
          frame_out[frame_n-1].last = 1'b1;
          for (i = 0; i < frame_n; i++) reply_q.push_back(frame_out[i]);
        end else begin
          if (lk_count == 8'd2) lk_op = b;
          else if (lk_count - 8'd3 < 8'd6) lk_pay[lk_count-8'd3] = b;
          lk_sum = lk_sum + b;
          lk_count = lk_count + 8'd1;
        end
      end
      default: begin
        lk_phase = LINK_HUNT;
        if (b == HDR_BYTE) begin
          for (i = 0; i < 6; i++) lk_pay[i] = 8'h00;
          lk_op = 8'h00;
          lk_sum = b;
          lk_count = 8'd1;
          lk_phase = LINK_LENGTH;
        end
      end
    endcase
  endtask

  // header, length, opcode, payload bytes, checksum
  task automatic queue_frame(input logic [7:0] op, input bit bad_sum);
    logic [7:0] len;
    logic [7:0] sum;
    int         i;
    len = 8'(4 + frame_pay.size());
    sum = HDR_BYTE + len + op;
    link_bytes.push_back(HDR_BYTE);
    link_bytes.push_back(len);
    link_bytes.push_back(op);
    for (i = 0; i < frame_pay.size(); i++) begin
      link_bytes.push_back(frame_pay[i]);
      sum = sum + frame_pay[i];
    end
    sum = 8'h00 - sum;
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    link_bytes.push_back(sum);
    frame_pay.delete();
  endtask

  task automatic fill_pay(input int n);
    int i;
    for (i = 0; i < n; i++) frame_pay.push_back(8'($urandom_range(0, 255)));
  endtask

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n || link_bytes.size() == 0) begin
      in_push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      in_push <= 1'b0;
    end else begin
      in_push <= 1'b1;
      in_rx_byte <= link_bytes[0];
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 48);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // receiver: stall pattern refreshed each time all sixteen of its bits have been used
  logic [15:0] pop_pattern = 16'hFFFF;
  int          pop_pos = 0;
  bit          draining = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (draining) begin
      out_pop <= 1'b1;
    end else begin
      out_pop <= pop_pattern[pop_pos];
      pop_pos = (pop_pos + 1) % 16;
      if (pop_pos == 0) begin
        case ($urandom_range(0, 4))
          0: pop_pattern = 16'hFFFF;
          1: pop_pattern = 16'h0000;
          2, 3: pop_pattern = 16'($urandom);
          default: pop_pattern = 16'($urandom | $urandom);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        track_link_byte(in_rx_byte);
        void'(link_bytes.pop_front());
      end
      if (out_pop && !out_empty) begin
        if (reply_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: kind %0d reg_id %0d value %h last %0d",
                     out_kind, out_reg_id, out_reg_value, out_last);
          fail_count++;
        end else begin
          want_res = reply_q.pop_front();
          if (out_kind !== want_res.kind || out_reg_id !== want_res.reg_id ||
              out_reg_value !== want_res.reg_value || out_last !== want_res.last) begin
            if (fail_count < 10)
              $display("mismatch: expected kind %0d reg_id %0d value %h last %0d,",
                       want_res.kind, want_res.reg_id, want_res.reg_value, want_res.last,
                       " got kind %0d reg_id %0d value %h last %0d",
                       out_kind, out_reg_id, out_reg_value, out_last);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    int         i;
    int         rand_start;
    int         pick;
    int         npay;
    logic [7:0] op;
    bit         long_done;

    // noise while hunting, then malformed lengths
    link_bytes.push_back(8'h00);
    link_bytes.push_back(8'hFF);
    link_bytes.push_back(8'h5A);
    link_bytes.push_back(HDR_BYTE);
    link_bytes.push_back(8'h03);
    link_bytes.push_back(HDR_BYTE);
    link_bytes.push_back(8'h00);

    for (i = 0; i < 11; i++) begin
      frame_pay.push_back((i % 2 == 0) ? 8'hFF : 8'h00);
      queue_frame(plain_ops[i], 1'b0);
    end
    frame_pay.push_back(DZOOM_ON);  queue_frame(OP_DZOOM, 1'b0);
    frame_pay.push_back(8'h03);     queue_frame(OP_DZOOM, 1'b0);
    frame_pay.push_back(8'h00);     queue_frame(OP_AGC, 1'b0);
    frame_pay.push_back(8'h01);     queue_frame(OP_AGC, 1'b0);
    frame_pay = '{8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78};
    queue_frame(OP_LENS, 1'b0);
    frame_pay = '{8'h9A, 8'hBC};
    queue_frame(OP_LENS, 1'b0);  // missing payload reads as zero
    queue_frame(OP_LENS, 1'b0);  // shortest frame
    for (i = 0; i < 4; i++) begin
      frame_pay.push_back(ext_subs[i]);
      fill_pay(1);
      queue_frame(OP_EXT, 1'b0);
    end
    frame_pay = '{8'h11, 8'h22};
    queue_frame(OP_EXT, 1'b0);
    frame_pay.push_back(SUB_VERSION);
    fill_pay(5);
    queue_frame(OP_VERSION, 1'b0);
    frame_pay.push_back(8'hB3);
    fill_pay(5);
    queue_frame(OP_VERSION, 1'b0);
    fill_pay(2);
    queue_frame(8'hBA, 1'b0);
    fill_pay(1);
    queue_frame(8'h00, 1'b0);
    frame_pay.push_back(SUB_IPM);
    queue_frame(OP_EXT, 1'b1);  // ping ignores the checksum
    fill_pay(1);
    queue_frame(OP_COOLED, 1'b1);
    frame_pay.push_back(SUB_VERSION);
    fill_pay(9);
    queue_frame(OP_VERSION, 1'b0);

    rand_start = link_bytes.size();
    long_done = 1'b0;
    while (link_bytes.size() - rand_start < 265) begin
      pick = $urandom_range(0, 99);
      if (!long_done && link_bytes.size() - rand_start > 60) begin
        long_done = 1'b1;
        frame_pay.push_back(SUB_VERSION);
        fill_pay(120);
        queue_frame(OP_VERSION, 1'b0);
      end else if (pick < 78) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: op = plain_ops[$urandom_range(0, 10)];
          11: op = OP_DZOOM;
          12: op = OP_AGC;
          13: op = OP_LENS;
          14: op = OP_EXT;
          15: op = OP_VERSION;
          16: op = 8'hBA;
          default: op = 8'($urandom_range(0, 255));
        endcase
        npay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(1, 6);
        fill_pay(npay);
        if (npay > 0 && $urandom_range(0, 4) != 0) begin
          case (op)
            OP_DZOOM:   frame_pay[0] = DZOOM_ON;
            OP_AGC:     frame_pay[0] = 8'h00;
            OP_EXT:     frame_pay[0] = ext_subs[$urandom_range(0, 3)];
            OP_VERSION: frame_pay[0] = SUB_VERSION;
            default: ;
          endcase
        end
        queue_frame(op, pick >= 70);
      end else if (pick < 85) begin
        fill_pay(1);
        queue_frame(OP_EXT, 1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        link_bytes.push_back(HDR_BYTE);
        link_bytes.push_back(8'($urandom_range(0, 3)));
      end else if (pick < 95) begin
        npay = $urandom_range(1, 3);
        for (i = 0; i < npay; i++) link_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        link_bytes.push_back(HDR_BYTE);
        npay = $urandom_range(4, 12);
        link_bytes.push_back(8'(npay));
        npay = $urandom_range(0, npay - 2);
        for (i = 0; i < npay; i++) link_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (link_bytes.size() != 0 || reply_q.size() != 0) @(posedge clk);
    draining = 1'b1;
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("thermal_head_reply_parser_core verification clean");
    end else begin
      $display("thermal_head_reply_parser_core verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("thermal_head_reply_parser_core verification failed");
    $finish;
  end

endmodule
